// ===== design/varint_length_deframer_unit_defines.svh =====
// Assertion macros shared by the varint length deframer RTL.
`ifndef VARINT_LENGTH_DEFRAMER_UNIT_DEFINES_SVH
`define VARINT_LENGTH_DEFRAMER_UNIT_DEFINES_SVH

// Checked on every edge outside reset.
`define VLD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define VLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/vld_pkg.sv =====
// Package: widths, result kinds and beat types of the varint length deframer.
`default_nettype none
package vld_pkg;

   localparam int MaxPayload     = 256;
   localparam int MaxPrefixBytes = 5;
   localparam int GroupW         = 7;
   localparam int ByteW          = 8;
   localparam int LenW           = $clog2(MaxPayload + 1);
   localparam int AccW           = GroupW * MaxPrefixBytes;
   localparam int PrefixCntW     = $clog2(MaxPrefixBytes);
   localparam int KindW          = 2;

   localparam logic [LenW-1:0] LimitReset = LenW'(MaxPayload);

   typedef enum logic [KindW-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [ByteW-1:0]       data;
      logic                   last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } step_type;

endpackage
`default_nettype wire

// ===== design/varint_length_deframer_unit.sv =====
// A beat that makes a result shows it on rsp_ in the cycle after acceptance.
// Throughput: one req_ beat per cycle; req_stall rises only while a result is held.
// The single result register is the only buffering; it frees as its beat is taken.
// Reset (synchronous, high): awaiting a prefix, no result held, length limit 256.
// Prefix bytes give no result until the length is settled, rejected or empty.
`default_nettype none
`include "varint_length_deframer_unit_defines.svh"
module varint_length_deframer_unit (
   input  wire                        clock,
   input  wire                        reset,
   // received byte beats
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [vld_pkg::ByteW-1:0]  req_rx_byte,
   // result beats
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [vld_pkg::KindW-1:0]  rsp_kind,
   output logic [vld_pkg::ByteW-1:0]  rsp_data,
   output logic                       rsp_last,
   // length limit register
   input  wire                        csr_wr_en,
   input  wire  [vld_pkg::LenW-1:0]   csr_wr_data
);
   import vld_pkg::*;

   step_type   step;
   result_type rsp_result;
   logic       out_ready;
   logic       req_accept;

   // a beat is taken whenever the result register is empty or emptying
   assign req_stall  = !out_ready;
   assign req_accept = req_valid && out_ready;

   // prefix decode and payload counting; at most one result per beat
   vld_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step)
   );

   // result register: holds a result beat while rsp_ stalls
   vld_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .ready      (out_ready)
   );

   assign rsp_kind = rsp_result.kind;
   assign rsp_data = rsp_result.data;
   assign rsp_last = rsp_result.last;

   `VLD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result held after reset")
   `VLD_ASSERT(a_marker_last, clock, reset, (rsp_valid && rsp_kind != KIND_PAYLOAD) |-> (rsp_last && rsp_data == '0), "empty or error beat without last or with data")
   `VLD_ASSERT(a_no_overwrite, clock, reset, (rsp_valid && rsp_stall) |-> !step.valid, "result produced over a stalled beat")

endmodule
`default_nettype wire

// ===== design/vld_frame_core.sv =====
// Prefix decode, payload count and limit register of the varint length deframer.
`default_nettype none
`include "varint_length_deframer_unit_defines.svh"
module vld_frame_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        accept,
   input  wire  [vld_pkg::ByteW-1:0]  rx_byte,
   input  wire                        csr_wr_en,
   input  wire  [vld_pkg::LenW-1:0]   csr_wr_data,
   output vld_pkg::step_type          step
);
   import vld_pkg::*;

   logic                  in_payload_ff, in_payload_in;
   logic [LenW-1:0]       bytes_left_ff, bytes_left_in;
   logic [LenW-1:0]       acc_lo_ff, acc_lo_in;
   logic                  acc_hi_ff, acc_hi_in;
   logic [PrefixCntW-1:0] prefix_cnt_ff, prefix_cnt_in;
   logic [LenW-1:0]       limit_ff;

   logic [AccW-1:0]       placed;
   logic [LenW-1:0]       len_lo;
   logic                  len_hi;
   logic [LenW-1:0]       eff_limit;

   // group shifted to its 7-bit slot; only the low LenW bits can pass the limit
   assign placed    = AccW'(rx_byte[GroupW-1:0]) << (GroupW * prefix_cnt_ff);
   assign len_lo    = acc_lo_ff | placed[LenW-1:0];
   assign len_hi    = acc_hi_ff | (|placed[AccW-1:LenW]);
   assign eff_limit = (limit_ff > LimitReset) ? LimitReset : limit_ff;

   always_comb begin
      in_payload_in = in_payload_ff;
      bytes_left_in = bytes_left_ff;
      acc_lo_in     = acc_lo_ff;
      acc_hi_in     = acc_hi_ff;
      prefix_cnt_in = prefix_cnt_ff;
      step          = '0;
      step.result.kind = KIND_PAYLOAD;
      if (accept) begin
         if (in_payload_ff) begin
            step.valid       = 1'b1;
            step.result.kind = KIND_PAYLOAD;
            step.result.data = rx_byte;
            step.result.last = (bytes_left_ff <= LenW'(1));
            bytes_left_in    = bytes_left_ff - LenW'(1);
            in_payload_in    = (bytes_left_ff > LenW'(1));
         end else if (rx_byte[ByteW-1]) begin
            if (prefix_cnt_ff == PrefixCntW'(MaxPrefixBytes - 1)) begin
               step.valid       = 1'b1;
               step.result.kind = KIND_ERROR;
               step.result.last = 1'b1;
               acc_lo_in        = '0;
               acc_hi_in        = 1'b0;
               prefix_cnt_in    = '0;
            end else begin
               acc_lo_in     = len_lo;
               acc_hi_in     = len_hi;
               prefix_cnt_in = prefix_cnt_ff + PrefixCntW'(1);
            end
         end else begin
            acc_lo_in     = '0;
            acc_hi_in     = 1'b0;
            prefix_cnt_in = '0;
            if (len_hi || (len_lo > eff_limit)) begin
               step.valid       = 1'b1;
               step.result.kind = KIND_ERROR;
               step.result.last = 1'b1;
            end else if (len_lo == '0) begin
               step.valid       = 1'b1;
               step.result.kind = KIND_EMPTY;
               step.result.last = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               bytes_left_in = len_lo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         bytes_left_ff <= '0;
         acc_lo_ff     <= '0;
         acc_hi_ff     <= 1'b0;
         prefix_cnt_ff <= '0;
         limit_ff      <= LimitReset;
      end else begin
         in_payload_ff <= in_payload_in;
         bytes_left_ff <= bytes_left_in;
         acc_lo_ff     <= acc_lo_in;
         acc_hi_ff     <= acc_hi_in;
         prefix_cnt_ff <= prefix_cnt_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   `VLD_ASSERT(a_payload_count_live, clock, reset, in_payload_ff |-> (bytes_left_ff != '0), "payload state with zero bytes left")
   `VLD_ASSERT(a_prefix_count_bound, clock, reset, prefix_cnt_ff < PrefixCntW'(MaxPrefixBytes), "prefix count beyond maximum")
   `VLD_ASSERT(a_prefix_idle_in_payload, clock, reset, in_payload_ff |-> (prefix_cnt_ff == '0 && acc_lo_ff == '0 && !acc_hi_ff), "prefix state not cleared during payload")

endmodule
`default_nettype wire

// ===== design/vld_out_reg.sv =====
// Result register of the varint length deframer.
`default_nettype none
module vld_out_reg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire vld_pkg::step_type step,
   input  wire                 rsp_stall,
   output logic                rsp_valid,
   output vld_pkg::result_type rsp_result,
   output logic                ready
);
   import vld_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   assign ready      = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step.valid) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.valid) begin
         result_ff <= step.result;
      end
   end

endmodule
`default_nettype wire
